// ----- rtl/aabb_frustum_cull_core_assert.svh -----
// Assertion macros for the box culling core.
`ifndef AABB_FRUSTUM_CULL_CORE_ASSERT_SVH
`define AABB_FRUSTUM_CULL_CORE_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define AFC_ASSERT_SAME(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define AFC_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/aafc_pkg.sv -----
package aafc_pkg;
    localparam int FRAC_BITS   = 16;
    localparam int CORNERS     = 8;
    localparam int CNT_W       = $clog2(CORNERS);
    localparam int FIX_W       = 32;
    localparam int NUM_W       = FIX_W + FRAC_BITS;
    localparam int SUM_W       = 2 * FIX_W + 2;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int IN_W        = 6 * FIX_W;
    localparam int OUT_W       = 200;

    typedef logic signed [FIX_W-1:0] t_fix;

    localparam t_fix FIX_MAX = t_fix'(32'h7FFF_FFFF);
    localparam t_fix FIX_MIN = t_fix'(32'h8000_0000);
    localparam t_fix FIX_ONE = t_fix'(64'sd1 <<< FRAC_BITS);

    typedef struct packed {
        logic last;
        t_fix z;
        t_fix y;
        t_fix x;
    } t_corner;
endpackage

// ----- rtl/aafc_front.sv -----
module aafc_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [aafc_pkg::IN_W-1:0] i_s_tdata,
    input  logic                     i_full,
    output logic                     o_push,
    output aafc_pkg::t_corner        o_corner
);
    import aafc_pkg::*;

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    t_fix             r_lo [3];
    t_fix             r_hi [3];
    logic             w_last;
    logic             w_done;
    logic             w_accept;

    assign w_last     = (r_cnt == CNT_W'(CORNERS - 1));
    assign o_push     = r_busy && !i_full;
    assign w_done     = o_push && w_last;
    assign o_s_tready = !r_busy || w_done;
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end else if (o_push) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int a = 0; a < 3; a++) begin
                r_lo[a] <= t_fix'(i_s_tdata[a*FIX_W +: FIX_W]);
                r_hi[a] <= t_fix'(i_s_tdata[(a+3)*FIX_W +: FIX_W]);
            end
        end
    end

    assign o_corner.x    = r_cnt[0] ? r_hi[0] : r_lo[0];
    assign o_corner.y    = r_cnt[1] ? r_hi[1] : r_lo[1];
    assign o_corner.z    = r_cnt[2] ? r_hi[2] : r_lo[2];
    assign o_corner.last = w_last;
endmodule

// ----- rtl/aafc_fifo.sv -----
module aafc_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  aafc_pkg::t_corner i_din,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output aafc_pkg::t_corner o_dout
);
    import aafc_pkg::*;

    t_corner             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_AW:0]   r_cnt;
    logic                w_do_push;
    logic                w_do_pop;

    assign o_full    = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_dout    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) r_wp <= r_wp + QUEUE_AW'(1);
            if (w_do_pop)  r_rp <= r_rp + QUEUE_AW'(1);
            if (w_do_push && !w_do_pop) r_cnt <= r_cnt + (QUEUE_AW+1)'(1);
            else if (w_do_pop && !w_do_push) r_cnt <= r_cnt - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) r_mem[r_wp] <= i_din;
    end
endmodule

// ----- rtl/aafc_xform.sv -----
module aafc_xform (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  aafc_pkg::t_corner i_corner,
    input  aafc_pkg::t_fix    i_mat [4][4],
    output logic              o_valid,
    output logic              o_last,
    output aafc_pkg::t_fix    o_clip [4]
);
    import aafc_pkg::*;

    t_fix                    w_pt [4];
    logic signed [2*FIX_W-1:0] r_prod [4][4];
    logic                    r_v1, r_l1, r_v2, r_l2;
    logic signed [SUM_W-1:0] w_sum [4];
    logic signed [SUM_W-1:0] w_sh  [4];
    t_fix                    r_clip [4];

    assign w_pt[0] = i_corner.x;
    assign w_pt[1] = i_corner.y;
    assign w_pt[2] = i_corner.z;
    assign w_pt[3] = FIX_ONE;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            w_sum[r] = SUM_W'(r_prod[r][0]) + SUM_W'(r_prod[r][1])
                     + SUM_W'(r_prod[r][2]) + SUM_W'(r_prod[r][3]);
            w_sh[r]  = w_sum[r] >>> FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l1 <= i_corner.last;
            r_l2 <= r_l1;
            for (int r = 0; r < 4; r++) begin
                for (int j = 0; j < 4; j++) begin
                    r_prod[r][j] <= (2*FIX_W)'(i_mat[r][j]) * (2*FIX_W)'(w_pt[j]);
                end
                if (w_sh[r] > SUM_W'(FIX_MAX))      r_clip[r] <= FIX_MAX;
                else if (w_sh[r] < SUM_W'(FIX_MIN)) r_clip[r] <= FIX_MIN;
                else                                r_clip[r] <= w_sh[r][FIX_W-1:0];
            end
        end
    end

    assign o_valid = r_v2;
    assign o_last  = r_l2;
    assign o_clip  = r_clip;
endmodule

// ----- rtl/aafc_div.sv -----
module aafc_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic           i_last,
    input  aafc_pkg::t_fix i_c,
    input  aafc_pkg::t_fix i_w,
    output logic           o_valid,
    output logic           o_last,
    output aafc_pkg::t_fix o_q
);
    import aafc_pkg::*;

    typedef struct packed {
        logic last;
        logic neg;
        logic wz;
        logic cpos;
        logic cneg;
    } t_dtag;

    logic             r_v   [NUM_W+1];
    t_dtag            r_tag [NUM_W+1];
    logic [NUM_W-1:0] r_nq  [NUM_W+1];
    logic [FIX_W-1:0] r_rem [NUM_W+1];
    logic [FIX_W-1:0] r_den [NUM_W+1];
    logic [FIX_W-1:0] w_cmag;
    logic [FIX_W-1:0] w_wmag;
    logic             r_ov;
    logic             r_ol;
    t_fix             r_q;
    logic [NUM_W-1:0] w_qm;

    assign w_cmag = i_c[FIX_W-1] ? FIX_W'(-i_c) : FIX_W'(i_c);
    assign w_wmag = i_w[FIX_W-1] ? FIX_W'(-i_w) : FIX_W'(i_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nq[0]       <= {w_cmag, {FRAC_BITS{1'b0}}};
            r_rem[0]      <= '0;
            r_den[0]      <= w_wmag;
            r_tag[0].last <= i_last;
            r_tag[0].neg  <= i_c[FIX_W-1] ^ i_w[FIX_W-1];
            r_tag[0].wz   <= (i_w == '0);
            r_tag[0].cpos <= (i_c > 0);
            r_tag[0].cneg <= i_c[FIX_W-1];
        end
    end

    for (genvar k = 1; k <= NUM_W; k++) begin : g_stage
        logic [FIX_W:0] w_trial;
        logic [FIX_W:0] w_diff;
        logic           w_ge;

        assign w_trial = {r_rem[k-1], r_nq[k-1][NUM_W-1]};
        assign w_diff  = w_trial - {1'b0, r_den[k-1]};
        assign w_ge    = (w_trial >= {1'b0, r_den[k-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? w_diff[FIX_W-1:0] : w_trial[FIX_W-1:0];
                r_nq[k]  <= {r_nq[k-1][NUM_W-2:0], w_ge};
                r_den[k] <= r_den[k-1];
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign w_qm = r_nq[NUM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[NUM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ol <= r_tag[NUM_W].last;
            if (r_tag[NUM_W].wz) begin
                if (r_tag[NUM_W].cpos)      r_q <= FIX_MAX;
                else if (r_tag[NUM_W].cneg) r_q <= FIX_MIN;
                else                        r_q <= '0;
            end else if (!r_tag[NUM_W].neg) begin
                if (w_qm > NUM_W'(FIX_MAX)) r_q <= FIX_MAX;
                else                        r_q <= t_fix'(w_qm[FIX_W-1:0]);
            end else begin
                if (w_qm > NUM_W'(33'h1_0000_0000 >> 1)) r_q <= FIX_MIN;
                else                        r_q <= t_fix'(-w_qm[FIX_W-1:0]);
            end
        end
    end

    assign o_valid = r_ov;
    assign o_last  = r_ol;
    assign o_q     = r_q;
endmodule

// ----- rtl/aabb_frustum_cull_core.sv -----
// Box frustum culling core.
// Input channel (i_s_*): one item is one box, six signed Q16.16 coordinates.
// Output channel (o_m_*): one item per box, visible flag and the projected
// per-axis minimum and maximum, in input order.
// Configuration: write i_cfg_wdata to matrix register i_cfg_addr when
// i_cfg_we is high; indexes 8 and above are ignored. Write only while idle.
// Throughput: one corner per cycle unless the pipe holds, through the shared
// matrix multiplier and three pipelined dividers (one quotient bit a stage).
// A new box is taken while the last corner of the previous one is issued.
// From box accept to result valid the data passes the queue, two multiply-sum
// stages, 50 divider stages and the min/max accumulate.
// A corner queue decouples the corner generator from the arithmetic pipe;
// the pipe holds when a result waits and i_m_tready is low, and the front
// keeps filling the queue until it is full.
// Reset clears the matrix to zero and empties all pipeline stages.
module aabb_frustum_cull_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic [aafc_pkg::IN_W-1:0]        i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // visible, proj_min_x, proj_min_y, proj_min_z, proj_max_x, proj_max_y,
    // proj_max_z, zero fill
    output logic [aafc_pkg::OUT_W-1:0]       o_m_tdata,
    input  logic                             i_cfg_we,
    input  logic [aafc_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [aafc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import aafc_pkg::*;
    `include "aabb_frustum_cull_core_assert.svh"

    t_fix    r_mat [4][4];
    logic    w_push;
    logic    w_full;
    t_corner w_fcorner;
    t_corner w_qcorner;
    logic    w_empty;
    logic    w_en;
    logic    w_pop;
    logic    w_xv, w_xl;
    t_fix    w_clip [4];
    logic    w_dv [3];
    logic    w_dl [3];
    t_fix    w_q  [3];
    logic    r_first;
    t_fix    r_amin [3];
    t_fix    r_amax [3];
    t_fix    n_min  [3];
    t_fix    n_max  [3];
    logic    n_vis;
    logic    r_out_valid;
    logic    r_vis;
    t_fix    r_omin [3];
    t_fix    r_omax [3];
    logic    w_take;

    assign w_en  = !r_out_valid || i_m_tready;
    assign w_pop = w_en && !w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 4; r++)
                for (int j = 0; j < 4; j++)
                    r_mat[r][j] <= '0;
        end else if (i_cfg_we && !i_cfg_addr[CFG_IDX_W-1]) begin
            r_mat[i_cfg_addr[2:1]][{i_cfg_addr[0], 1'b0}] <= t_fix'(i_cfg_wdata[63:32]);
            r_mat[i_cfg_addr[2:1]][{i_cfg_addr[0], 1'b1}] <= t_fix'(i_cfg_wdata[31:0]);
        end
    end

    aafc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_corner   (w_fcorner)
    );

    aafc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_din   (w_fcorner),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_dout  (w_qcorner)
    );

    aafc_xform u_xform (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_pop),
        .i_corner (w_qcorner),
        .i_mat    (r_mat),
        .o_valid  (w_xv),
        .o_last   (w_xl),
        .o_clip   (w_clip)
    );

    for (genvar a = 0; a < 3; a++) begin : g_div
        aafc_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_xv),
            .i_last  (w_xl),
            .i_c     (w_clip[a]),
            .i_w     (w_clip[3]),
            .o_valid (w_dv[a]),
            .o_last  (w_dl[a]),
            .o_q     (w_q[a])
        );
    end

    assign w_take = w_en && w_dv[0];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_min[a] = (r_first || w_q[a] < r_amin[a]) ? w_q[a] : r_amin[a];
            n_max[a] = (r_first || w_q[a] > r_amax[a]) ? w_q[a] : r_amax[a];
        end
        n_vis = 1'b1;
        if (n_max[2] <= 0) n_vis = 1'b0;
        if (n_max[0] <= -FIX_ONE || n_min[0] >= FIX_ONE) n_vis = 1'b0;
        if (n_max[1] <= -FIX_ONE || n_min[1] >= FIX_ONE) n_vis = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) r_first <= w_dl[0] && w_dl[1] && w_dl[2];
            if (w_take && w_dl[0]) r_out_valid <= 1'b1;
            else if (i_m_tready)   r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_amin <= n_min;
            r_amax <= n_max;
            if (w_dl[0]) begin
                r_vis  <= n_vis;
                r_omin <= n_min;
                r_omax <= n_max;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_omax[2], r_omax[1], r_omax[0],
                         r_omin[2], r_omin[1], r_omin[0], r_vis};

    `AFC_ASSERT_NEXT(a_last_gives_result, w_take && w_dl[0], o_m_tvalid,
        "last corner did not produce a result")
    `AFC_ASSERT_SAME(a_result_needs_last, $rose(o_m_tvalid), $past(w_take && w_dl[0]),
        "result without a last corner")
    `AFC_ASSERT_SAME(a_axes_aligned, w_dv[0], w_dv[1] && w_dv[2] && w_dl[0] == w_dl[1],
        "divider lanes out of step")
endmodule
